### src/perm_enum_pkg.sv
// Shared types and constants for the permutation enumerator.
package perm_enum_pkg;

  localparam int SIZE_W  = 4;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 16;
  localparam int NIB_W   = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd4;

  // controller -> datapath
  typedef struct packed {
    logic restart;   // load the first arrangement
    logic miss;      // this request finds nothing
    logic advance;   // start a backtrack at the deepest level
    logic back;      // one backtrack step
    logic fill;      // one refill step
    logic load;      // write the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic at_last;
    logic back_found;
    logic at_bottom;  // depth is 1
    logic at_top;     // depth equals N
  } status_t;

endpackage

### src/perm_enum_ctrl.sv
// Sequencer for requests: accept, backtrack, refill, result hand-off.
module perm_enum_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output perm_enum_pkg::cmd_t     cmd,
  input  perm_enum_pkg::status_t  status
);
  import perm_enum_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_BACK   = 4'b0010,
    S_FILL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            cmd.restart = 1'b1;
            state_next  = S_FINISH;
          end else if (status.walk_done || status.at_last) begin
            cmd.miss   = 1'b1;
            state_next = S_FINISH;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_BACK;
          end
        end
      end
      S_BACK: begin
        cmd.back = 1'b1;
        if (status.back_found) begin
          state_next = status.at_top ? S_FINISH : S_FILL;
        end else if (status.at_bottom) begin
          state_next = S_FINISH;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.at_top) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/perm_enum_dp.sv
// Walk state: level per position, stack of chosen positions, free mask, result register.
module perm_enum_dp #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [perm_enum_pkg::SIZE_W-1:0]     cfg_wdata,
  input  perm_enum_pkg::cmd_t                  cmd,
  output perm_enum_pkg::status_t               status,
  output logic [perm_enum_pkg::WORD_W-1:0]     perm_word,
  output logic [perm_enum_pkg::INDEX_W-1:0]    perm_index,
  output logic                                 is_final,
  output logic                                 exhausted
);
  import perm_enum_pkg::*;

  localparam int NW = $clog2(MAX_POSITIONS + 1);
  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int DW = $clog2(MAX_POSITIONS + 2);
  localparam int WORD_POS = WORD_W / NIB_W;
  localparam int OUT_POS  = (MAX_POSITIONS < WORD_POS) ? MAX_POSITIONS : WORD_POS;

  logic [SIZE_W-1:0]  size;
  logic               walk_done, walk_done_next;
  logic               miss, miss_next;
  logic [DW-1:0]      depth, depth_next;
  logic [INDEX_W-1:0] count, count_next;
  logic [NW-1:0]      level [MAX_POSITIONS];
  logic [NW-1:0]      level_next [MAX_POSITIONS];
  logic [PW-1:0]      stack [MAX_POSITIONS];
  logic [PW-1:0]      stack_next [MAX_POSITIONS];
  logic [MAX_POSITIONS-1:0] free, free_next;

  logic [NW-1:0]            n;
  logic [DW-1:0]            depth_m1;
  logic [PW-1:0]            slot;
  logic [PW-1:0]            p;
  logic [MAX_POSITIONS-1:0] above_mask, low_mask;
  logic [PW:0]              above_hit, low_hit;
  logic                     at_last;
  logic [WORD_W-1:0]        word_pack;

  function automatic logic [PW:0] lowest(input logic [MAX_POSITIONS-1:0] m);
    logic [PW:0] res;
    res = '0;
    for (int i = MAX_POSITIONS - 1; i >= 0; i--) begin
      if (m[i]) res = {1'b1, PW'(i)};
    end
    return res;
  endfunction

  // out-of-range sizes clamp to 1..MAX_POSITIONS
  assign n = (size == '0) ? NW'(1) :
             (size > SIZE_W'(MAX_POSITIONS)) ? NW'(MAX_POSITIONS) : NW'(size);

  assign depth_m1 = depth - DW'(1);
  assign slot     = depth_m1[PW-1:0];
  assign p        = stack[slot];

  always_comb begin
    for (int i = 0; i < MAX_POSITIONS; i++) begin
      above_mask[i] = free[i] && (PW'(i) > p) && (NW'(i) < n);
      low_mask[i]   = free[i] && (NW'(i) < n);
    end
  end

  assign above_hit = lowest(above_mask);
  assign low_hit   = lowest(low_mask);

  // last arrangement: level d sits at position n-d for every level
  always_comb begin
    logic [NW-1:0] tgt;
    at_last = 1'b1;
    for (int k = 0; k < MAX_POSITIONS; k++) begin
      tgt = n - NW'(k) - NW'(1);
      if ((NW'(k) < n) && (stack[k] != tgt[PW-1:0])) at_last = 1'b0;
    end
  end

  always_comb begin
    word_pack = '0;
    for (int i = 0; i < OUT_POS; i++) begin
      word_pack[NIB_W*i +: NIB_W] = NIB_W'(level[i]);
    end
  end

  assign status.walk_done  = walk_done;
  assign status.at_last    = at_last;
  assign status.back_found = above_hit[PW];
  assign status.at_bottom  = (depth == DW'(1));
  assign status.at_top     = (depth == DW'(n));

  always_comb begin
    level_next     = level;
    stack_next     = stack;
    free_next      = free;
    depth_next     = depth;
    count_next     = count;
    miss_next      = miss;
    walk_done_next = walk_done;

    if (cmd.restart) begin
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        level_next[i] = (NW'(i) < n) ? NW'(i + 1) : '0;
        stack_next[i] = (NW'(i) < n) ? PW'(i) : '0;
      end
      free_next      = '0;
      depth_next     = DW'(n);
      count_next     = '0;
      miss_next      = 1'b0;
      walk_done_next = 1'b0;
    end
    if (cmd.miss) begin
      miss_next = 1'b1;
    end
    if (cmd.advance) begin
      depth_next = DW'(n);
      miss_next  = 1'b0;
    end
    if (cmd.back) begin
      level_next[p] = '0;
      free_next[p]  = 1'b1;
      if (above_hit[PW]) begin
        level_next[above_hit[PW-1:0]] = NW'(depth);
        stack_next[slot]              = above_hit[PW-1:0];
        free_next[above_hit[PW-1:0]]  = 1'b0;
        depth_next                    = depth + DW'(1);
        count_next                    = count + INDEX_W'(1);
      end else begin
        depth_next = depth_m1;
        if (depth == DW'(1)) miss_next = 1'b1;
      end
    end
    if (cmd.fill) begin
      level_next[low_hit[PW-1:0]] = NW'(depth);
      stack_next[slot]            = low_hit[PW-1:0];
      free_next[low_hit[PW-1:0]]  = 1'b0;
      depth_next                  = depth + DW'(1);
    end
    if (cmd.load && miss) begin
      walk_done_next = 1'b1;
      depth_next     = '0;
    end
    if (cfg_we) begin
      walk_done_next = 1'b1;
      depth_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= SIZE_RESET;
      walk_done <= 1'b1;
      miss      <= 1'b0;
      depth     <= '0;
      count     <= '0;
      free      <= '0;
      for (int i = 0; i < MAX_POSITIONS; i++) begin
        level[i] <= '0;
        stack[i] <= '0;
      end
    end else begin
      if (cfg_we) size <= cfg_wdata;
      walk_done <= walk_done_next;
      miss      <= miss_next;
      depth     <= depth_next;
      count     <= count_next;
      free      <= free_next;
      level     <= level_next;
      stack     <= stack_next;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (miss) begin
        perm_word  <= '0;
        perm_index <= '0;
        is_final   <= 1'b0;
        exhausted  <= 1'b1;
      end else begin
        perm_word  <= word_pack;
        perm_index <= count;
        is_final   <= at_last;
        exhausted  <= 1'b0;
      end
    end
  end

endmodule

### src/permutation_enumerator.sv
// Top level of the permutation enumerator: controller plus walk datapath.
//
// Each request either restarts the walk (restart=1) and returns the first of the N!
// arrangements, or returns the next arrangement in recursive-visit order, with its ordinal
// and a last flag; after the last one, or after reset or a size write, an advance request
// returns exhausted=1 with all other fields zero. N is the written size clamped to
// 1..MAX_POSITIONS; writing it ends the current walk. A restart or an exhausted answer goes
// from accept straight to the state that loads the result register. An advance first
// backtracks from the deepest level, which never moves, to the first level that can take a
// higher free position, then refills the deeper levels, one stack level per cycle. A new
// request is taken while the previous result waits in the output register.
module permutation_enumerator #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [perm_enum_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [perm_enum_pkg::WORD_W-1:0]   perm_word,
  output logic [perm_enum_pkg::INDEX_W-1:0]  perm_index,
  output logic                               is_final,
  output logic                               exhausted
);
  import perm_enum_pkg::*;

  cmd_t    cmd;
  status_t status;

  perm_enum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  perm_enum_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status),
    .perm_word  (perm_word),
    .perm_index (perm_index),
    .is_final   (is_final),
    .exhausted  (exhausted)
  );

endmodule
